>>> hw/rtl/aebt_pkg.sv
package aebt_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_UPPER_LEVEL      = 3'd0;
  localparam logic [2:0] REG_LOWER_LEVEL      = 3'd1;
  localparam logic [2:0] REG_EXPOSURE_STEP    = 3'd2;
  localparam logic [2:0] REG_PULLBACK_STEP    = 3'd3;
  localparam logic [2:0] REG_EXPOSURE_CEILING = 3'd4;
  localparam logic [2:0] REG_EXPOSURE_FLOOR   = 3'd5;

  localparam logic [11:0] UPPER_LEVEL_RST      = 12'd1512;
  localparam logic [11:0] LOWER_LEVEL_RST      = 12'd1210;
  localparam logic [9:0]  EXPOSURE_STEP_RST    = 10'd164;
  localparam logic [11:0] PULLBACK_STEP_RST    = 12'd819;
  localparam logic [15:0] EXPOSURE_CEILING_RST = 16'd32768;
  localparam logic [15:0] EXPOSURE_FLOOR_RST   = 16'd14746;
  localparam logic [15:0] EXPOSURE_RST         = 16'd16384;
  localparam logic [16:0] EXPOSURE_MAX         = 17'h0FFFF;

  localparam int WORD_LUMA_MAX = 744;
  localparam int AVG_W         = 8;

  typedef struct packed {
    logic [11:0] upper_level;
    logic [11:0] lower_level;
    logic [9:0]  exposure_step;
    logic [11:0] pullback_step;
    logic [15:0] exposure_ceiling;
    logic [15:0] exposure_floor;
  } cfg_t;

  function automatic int sum_width(input int samples);
    return $clog2(WORD_LUMA_MAX * samples + 1);
  endfunction

  // each channel read as twice its 5-bit value
  function automatic logic [7:0] pixel_luma(input logic [15:0] px);
    return 8'({px[15:11], 1'b0}) + 8'({px[10:6], 1'b0}) + 8'({px[5:1], 1'b0});
  endfunction

  function automatic logic [9:0] word_luma(input logic [63:0] w);
    return 10'(pixel_luma(w[15:0])) + 10'(pixel_luma(w[31:16]))
         + 10'(pixel_luma(w[47:32])) + 10'(pixel_luma(w[63:48]));
  endfunction

endpackage

>>> hw/rtl/aebt_if.sv
interface aebt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixel_word;
  modport source(output valid, output pixel_word, input ready);
  modport sink(input valid, input pixel_word, output ready);
endinterface

interface aebt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] exposure_value;
  logic [7:0]  average_level;
  modport source(output valid, output exposure_value, output average_level, input ready);
  modport sink(input valid, input exposure_value, input average_level, output ready);
endinterface

>>> hw/rtl/aebt_cfg_regs.sv
module aebt_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aebt_pkg::ADDR_W-1:0] paddr,
  input  logic [aebt_pkg::DATA_W-1:0] pwdata,
  output logic [aebt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output aebt_pkg::cfg_t             cfg
);
  import aebt_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_level      <= UPPER_LEVEL_RST;
      cfg.lower_level      <= LOWER_LEVEL_RST;
      cfg.exposure_step    <= EXPOSURE_STEP_RST;
      cfg.pullback_step    <= PULLBACK_STEP_RST;
      cfg.exposure_ceiling <= EXPOSURE_CEILING_RST;
      cfg.exposure_floor   <= EXPOSURE_FLOOR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_UPPER_LEVEL:      cfg.upper_level      <= pwdata[11:0];
        REG_LOWER_LEVEL:      cfg.lower_level      <= pwdata[11:0];
        REG_EXPOSURE_STEP:    cfg.exposure_step    <= pwdata[9:0];
        REG_PULLBACK_STEP:    cfg.pullback_step    <= pwdata[11:0];
        REG_EXPOSURE_CEILING: cfg.exposure_ceiling <= pwdata[15:0];
        REG_EXPOSURE_FLOOR:   cfg.exposure_floor   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UPPER_LEVEL:      prdata = DATA_W'(cfg.upper_level);
      REG_LOWER_LEVEL:      prdata = DATA_W'(cfg.lower_level);
      REG_EXPOSURE_STEP:    prdata = DATA_W'(cfg.exposure_step);
      REG_PULLBACK_STEP:    prdata = DATA_W'(cfg.pullback_step);
      REG_EXPOSURE_CEILING: prdata = DATA_W'(cfg.exposure_ceiling);
      REG_EXPOSURE_FLOOR:   prdata = DATA_W'(cfg.exposure_floor);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/aebt_accum.sv
module aebt_accum #(
  parameter int SAMPLES = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [63:0]                                pixel_word,
  output logic                                       fs_valid,
  input  logic                                       fs_ready,
  output logic [aebt_pkg::sum_width(SAMPLES)-1:0]    fs_sum
);
  import aebt_pkg::*;

  localparam int SUM_W = sum_width(SAMPLES);
  localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [63:0]      word_q;
  logic             s1_valid;
  logic             acc_take;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [IDX_W-1:0] idx;
  logic             last;

  assign acc_take = s1_valid && (!fs_valid || fs_ready);
  assign in_ready = !s1_valid || acc_take;
  assign sum_next = sum + SUM_W'(word_luma(word_q));
  assign last     = (idx == IDX_W'(SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_q <= pixel_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      idx      <= '0;
      fs_valid <= 1'b0;
    end else begin
      if (acc_take && last) begin
        fs_valid <= 1'b1;
      end else if (fs_ready) begin
        fs_valid <= 1'b0;
      end
      if (acc_take) begin
        if (last) begin
          sum <= '0;
          idx <= '0;
        end else begin
          sum <= sum_next;
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && last) begin
      fs_sum <= sum_next;
    end
  end

endmodule

>>> hw/rtl/aebt_avg_div.sv
module aebt_avg_div #(
  parameter int SAMPLES = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    fs_valid,
  output logic                                    fs_ready,
  input  logic [aebt_pkg::sum_width(SAMPLES)-1:0] fs_sum,
  output logic                                    avg_valid,
  input  logic                                    avg_ready,
  output logic [aebt_pkg::AVG_W-1:0]              avg
);
  import aebt_pkg::*;

  localparam int SUM_W  = sum_width(SAMPLES);
  localparam int DIV    = 4 * SAMPLES;
  localparam int SH     = SUM_W + 9;
  localparam int MUL_W  = SH - 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] MUL = MUL_W'(((2 ** SH) + DIV - 1) / DIV);

  logic [PROD_W-1:0] prod;
  logic              take;

  // reciprocal multiply, exact for every sum of the frame
  assign prod     = PROD_W'(fs_sum) * PROD_W'(MUL);
  assign fs_ready = !avg_valid || avg_ready;
  assign take     = fs_valid && fs_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (fs_ready) begin
      avg_valid <= fs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      avg <= prod[SH+AVG_W-1:SH];
    end
  end

endmodule

>>> hw/rtl/aebt_exposure.sv
module aebt_exposure (
  input  logic                       clk,
  input  logic                       rst,
  input  aebt_pkg::cfg_t             cfg,
  input  logic                       avg_valid,
  output logic                       avg_ready,
  input  logic [aebt_pkg::AVG_W-1:0] avg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                exposure_value,
  output logic [aebt_pkg::AVG_W-1:0] average_level
);
  import aebt_pkg::*;

  logic [15:0] exposure_level;
  logic [11:0] lvl;
  logic [15:0] step;
  logic [16:0] inc_sum;
  logic [15:0] e_dec;
  logic [15:0] e_inc;
  logic [15:0] e_adj;
  logic [15:0] e_pb;
  logic [15:0] exposure_level_next;
  logic        take;

  assign avg_ready = !out_valid || out_ready;
  assign take      = avg_valid && avg_ready;

  always_comb begin
    lvl     = {avg, 4'b0000};
    step    = 16'(cfg.exposure_step);
    e_dec   = (exposure_level > step) ? exposure_level - step : '0;
    inc_sum = 17'(exposure_level) + 17'(step);
    e_inc   = (inc_sum > EXPOSURE_MAX) ? EXPOSURE_MAX[15:0] : inc_sum[15:0];
    if (lvl > cfg.upper_level) begin
      e_adj = e_dec;
    end else if (lvl < cfg.lower_level) begin
      e_adj = e_inc;
    end else begin
      e_adj = exposure_level;
    end
    if (e_adj > cfg.exposure_ceiling) begin
      e_pb = (e_adj > 16'(cfg.pullback_step)) ? e_adj - 16'(cfg.pullback_step) : '0;
    end else begin
      e_pb = e_adj;
    end
    exposure_level_next = (e_pb < cfg.exposure_floor) ? cfg.exposure_floor : e_pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_level <= EXPOSURE_RST;
      out_valid      <= 1'b0;
    end else if (take) begin
      exposure_level <= exposure_level_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      average_level <= avg;
    end
  end

  assign exposure_value = exposure_level;

endmodule

>>> hw/rtl/auto_exposure_brightness_tracker_top.sv
// auto exposure tracker on sampled framebuffer words
// pixels: one 64-bit word of four rgba16 pixels per transaction (valid/ready)
// result: one transaction per frame of SAMPLES words, carrying the updated
//   q2.14 exposure and the truncated average channel sum of the frame
// apb port: six registers at byte address 4*i; the user must write them only while idle (not enforced)
// throughput: one word per cycle while result.ready holds; four register stages (input,
//   frame sum, reciprocal multiply, exposure update) lie between the last word
//   of a frame and its result
// the exposure update runs once per frame in the output stage, which holds
//   the exposure state
// reset clears the frame sum and word count, loads exposure 1.0 and the
//   register defaults, and empties all stages
// a stalled result holds; stages behind it keep filling until each holds
//   one item, then pixels.ready drops
module auto_exposure_brightness_tracker_top #(
  parameter int SAMPLES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  aebt_in_if.sink                     pixels,
  aebt_out_if.source                  result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aebt_pkg::ADDR_W-1:0] paddr,
  input  logic [aebt_pkg::DATA_W-1:0] pwdata,
  output logic [aebt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import aebt_pkg::*;

  localparam int SUM_W = sum_width(SAMPLES);

  cfg_t             cfg;
  logic             fs_valid;
  logic             fs_ready;
  logic [SUM_W-1:0] fs_sum;
  logic             avg_valid;
  logic             avg_ready;
  logic [AVG_W-1:0] avg;

  aebt_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aebt_accum #(.SAMPLES(SAMPLES)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixels.valid),
    .in_ready   (pixels.ready),
    .pixel_word (pixels.pixel_word),
    .fs_valid   (fs_valid),
    .fs_ready   (fs_ready),
    .fs_sum     (fs_sum)
  );

  aebt_avg_div #(.SAMPLES(SAMPLES)) u_avg_div (
    .clk       (clk),
    .rst       (rst),
    .fs_valid  (fs_valid),
    .fs_ready  (fs_ready),
    .fs_sum    (fs_sum),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg       (avg)
  );

  aebt_exposure u_exposure (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .avg_valid      (avg_valid),
    .avg_ready      (avg_ready),
    .avg            (avg),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .exposure_value (result.exposure_value),
    .average_level  (result.average_level)
  );

endmodule

>>> hw/rtl/aebt_checker.sv
module aebt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] exposure_value,
  input logic [7:0]  average_level,
  input logic        pready
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(exposure_value)
      && $stable(average_level))
    else $error("stalled result changed");

  a_average_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> average_level <= 8'd186)
    else $error("average level out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind auto_exposure_brightness_tracker_top aebt_checker u_aebt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .exposure_value (result.exposure_value),
  .average_level  (result.average_level),
  .pready         (pready)
);
